### sv/rect_collision_table_scan_assert.svh
// Assertion macros used by the checker file of the rectangle table block.
`ifndef RECT_COLLISION_TABLE_SCAN_ASSERT_SVH
`define RECT_COLLISION_TABLE_SCAN_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define RCTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define RCTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rcts_pkg.sv
`default_nettype none

package rcts_pkg;

  // Bounds are 18-bit signed: position plus offset plus extent always fits.
  localparam int COORD_W    = 18;
  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 8;
  localparam int SCAN_CAP   = 16;

  // Item kinds.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Test modes.
  localparam logic [2:0] MODE_OVERLAP      = 3'd0;
  localparam logic [2:0] MODE_MEET         = 3'd1;
  localparam logic [2:0] MODE_EITHER_COVER = 3'd2;
  localparam logic [2:0] MODE_QUERY_COVER  = 3'd3;
  localparam logic [2:0] MODE_ENTRY_COVER  = 3'd4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t top;
    coord_t bottom;
  } box_t;

  // Forms a rectangle from position, offset and size.
  function automatic box_t build_box(input logic signed [15:0] pos_x,
                                     input logic signed [15:0] pos_y,
                                     input logic signed [15:0] off_x,
                                     input logic signed [15:0] off_y,
                                     input logic [14:0] rect_w,
                                     input logic [14:0] rect_h);
    box_t b;
    b.left   = COORD_W'(pos_x) + COORD_W'(off_x);
    b.top    = COORD_W'(pos_y) + COORD_W'(off_y);
    b.right  = b.left + $signed({3'b000, rect_w}) - coord_t'(1);
    b.bottom = b.top + $signed({3'b000, rect_h}) - coord_t'(1);
    return b;
  endfunction

endpackage

`default_nettype wire

### sv/rcts_box_test.sv
`default_nettype none

// Shared compare unit: tests the query rectangle against one table entry.
module rcts_box_test import rcts_pkg::*; (
  input  wire logic [2:0] mode,
  input  wire box_t       q_box,
  input  wire box_t       e_box,
  output logic            hit
);

  logic q_covers_e;
  logic e_covers_q;

  assign q_covers_e = (q_box.left <= e_box.left) && (q_box.right >= e_box.right) &&
                      (q_box.top <= e_box.top) && (q_box.bottom >= e_box.bottom);
  assign e_covers_q = (e_box.left <= q_box.left) && (e_box.right >= q_box.right) &&
                      (e_box.top <= q_box.top) && (e_box.bottom >= q_box.bottom);

  // Mode select; unused codes never match.
  always_comb begin
    case (mode)
      MODE_OVERLAP: begin
        hit = (q_box.left <= e_box.right) && (e_box.left <= q_box.right) &&
              (q_box.top <= e_box.bottom) && (e_box.top <= q_box.bottom);
      end
      MODE_MEET: begin
        hit = (q_box.right == e_box.left) || (q_box.bottom == e_box.top) ||
              (q_box.left == e_box.right) || (q_box.top == e_box.bottom);
      end
      MODE_EITHER_COVER: hit = q_covers_e || e_covers_q;
      MODE_QUERY_COVER:  hit = q_covers_e;
      MODE_ENTRY_COVER:  hit = e_covers_q;
      default:           hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### sv/rcts_box_table.sv
`default_nettype none

// Rectangle table: one write port, one read port with registered data.
module rcts_box_table import rcts_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire box_t              wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output box_t                   rd_data
);

  box_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/rect_collision_table_scan.sv
// Load transaction: accept, then the table write in the setup state; it gives no result.
// Query over N entries: accept, setup, then one entry per cycle (one table read port, one
// shared compare unit) unless an output stall holds it, then a final state that sends the
// held hit or the single miss result. A first-match hit ends it early, with no final state.
// An output stall holds the scan in place when a result is due. Synchronous reset clears the
// sequencer, the output valid and entry_count; table contents are undefined until loaded.
`default_nettype none

module rect_collision_table_scan import rcts_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write channel: entry_count.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [4:0]            cfg_data,
  // Input stream.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // entry_index[3:0], pos_x[19:4], pos_y[35:20], offset_x[51:36], offset_y[67:52],
  // rect_width[82:68], rect_height[97:83], zero fill[103:98]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func[0], mode[3:1], find_all[4]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  // Result stream.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // match_index[3:0], zero fill[7:4]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // found[0]
  output logic [0:0]                 m_axis_tuser,
  // last
  output logic                       m_axis_tlast
);

  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LIM_MAX = (TABLE_DEPTH < SCAN_CAP) ? TABLE_DEPTH : SCAN_CAP;
  localparam int CNT_W   = $clog2(LIM_MAX + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BUILD  = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [4:0]        entry_count;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic              scan_end;

  // Captured item fields.
  logic              func_r;
  logic [3:0]        slot_r;
  logic [2:0]        mode_r;
  logic              all_r;
  logic signed [15:0] pos_x_r;
  logic signed [15:0] pos_y_r;
  logic signed [15:0] off_x_r;
  logic signed [15:0] off_y_r;
  logic [14:0]       width_r;
  logic [14:0]       height_r;

  box_t              built_box;
  box_t              q_box;
  box_t              rd_box;
  logic              hit;

  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // Held hit in all-matches mode, sent once the next hit or the scan end is known.
  logic              pend_valid;
  logic [3:0]        pend_idx;
  logic              pend_load;
  logic              cnt_adv;

  // Output register.
  logic              out_valid;
  logic              out_found;
  logic [3:0]        out_idx;
  logic              out_last;
  logic              out_free;
  logic              push;
  logic              push_found;
  logic [3:0]        push_idx;
  logic              push_last;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-4){1'b0}}, out_idx};
  assign m_axis_tuser  = out_found;
  assign m_axis_tlast  = out_last;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // Scan limit saturates to the table size and the scan cap.
  always_comb begin
    if (int'(entry_count) > LIM_MAX) begin
      limit = CNT_W'(LIM_MAX);
    end else begin
      limit = CNT_W'(entry_count);
    end
  end

  assign cnt_inc  = cnt + CNT_W'(1);
  assign scan_end = (cnt_inc == limit);

  // Capture the item on acceptance.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_r   <= s_axis_tuser[0];
      mode_r   <= s_axis_tuser[3:1];
      all_r    <= s_axis_tuser[4];
      slot_r   <= s_axis_tdata[3:0];
      pos_x_r  <= s_axis_tdata[19:4];
      pos_y_r  <= s_axis_tdata[35:20];
      off_x_r  <= s_axis_tdata[51:36];
      off_y_r  <= s_axis_tdata[67:52];
      width_r  <= s_axis_tdata[82:68];
      height_r <= s_axis_tdata[97:83];
    end
  end

  assign built_box = build_box(pos_x_r, pos_y_r, off_x_r, off_y_r, width_r, height_r);

  // Table access: loads write in the setup cycle, scans read one entry ahead.
  assign wr_en   = (state == ST_BUILD) && (func_r == FUNC_LOAD) &&
                   (int'(slot_r) < TABLE_DEPTH);
  assign rd_en   = (state == ST_BUILD) || cnt_adv;
  assign rd_addr = (state == ST_BUILD) ? '0 : ADDR_W'(cnt_inc);

  rcts_box_table #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(slot_r)),
    .wr_data (built_box),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_box)
  );

  rcts_box_test u_test (
    .mode  (mode_r),
    .q_box (q_box),
    .e_box (rd_box),
    .hit   (hit)
  );

  // Sequencer decisions.
  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_found = 1'b0;
    push_idx   = 4'd0;
    push_last  = 1'b1;
    pend_load  = 1'b0;
    cnt_adv    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (func_r == FUNC_LOAD) begin
          state_next = ST_IDLE;
        end else if (limit == '0) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit && !all_r) begin
          // First match ends the query.
          if (out_free) begin
            push       = 1'b1;
            push_found = 1'b1;
            push_idx   = 4'(cnt);
            state_next = ST_IDLE;
          end
        end else if (!(hit && pend_valid && !out_free)) begin
          if (hit) begin
            pend_load = 1'b1;
            if (pend_valid) begin
              push       = 1'b1;
              push_found = 1'b1;
              push_idx   = pend_idx;
              push_last  = 1'b0;
            end
          end
          if (scan_end) begin
            state_next = ST_FINISH;
          end else begin
            cnt_adv = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        // Send the held hit as the final result, or the single miss result.
        if (out_free) begin
          push       = 1'b1;
          push_found = pend_valid;
          push_idx   = pend_valid ? pend_idx : 4'd0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_BUILD) begin
        pend_valid <= 1'b0;
      end else if (pend_load) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_BUILD) begin
      q_box <= built_box;
      cnt   <= '0;
    end else if (cnt_adv) begin
      cnt <= cnt_inc;
    end
    if (pend_load) begin
      pend_idx <= 4'(cnt);
    end
    if (push) begin
      out_found <= push_found;
      out_idx   <= push_idx;
      out_last  <= push_last;
    end
  end

endmodule

`default_nettype wire

### sv/rcts_checker.sv
`default_nettype none

`include "rect_collision_table_scan_assert.svh"

// Port-level checks on the rectangle table block.
module rcts_checker import rcts_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [0:0]            m_axis_tuser,
  input wire logic                  m_axis_tlast
);

  // A miss result is always the only one of its query and carries index zero.
  `RCTS_ASSERT_SAME(a_miss_is_final, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == '0), "miss result must be last with zero index")

  // Only a hit can be followed by further results of the same query.
  `RCTS_ASSERT_SAME(a_nonlast_is_hit, m_axis_tvalid && !m_axis_tlast, m_axis_tuser[0], "non-final result must report a hit")

  // The sequencer is busy in the cycle after taking an item.
  `RCTS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after a transaction")

  // A stalled result holds its contents.
  `RCTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind rect_collision_table_scan rcts_checker u_rcts_checker (.*);

`default_nettype wire
